// ===== rtl/zsbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_pkg: shared types and constants of the zlib stored-block framer
// Holds the job descriptor that travels from the front part to the back part,
// the output phase enum and the fixed constants of the zlib format.
// ----------------------------------------------------------------------------
package zsbf_pkg;

    localparam logic [31:0] MAX_BLOCK = 32'd65535;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [31:0] ADLER_INIT = 32'h0000_0001;

    typedef enum logic [1:0] {
        K_START  = 2'd0,
        K_MISUSE = 2'd1,
        K_DATA   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        hdr;        // a stored-block header opens this item
        logic        bfinal;
        logic [15:0] len;
        logic [7:0]  data;
        logic        adler;      // the checksum trails this item
        logic [31:0] adler_val;
    } t_job;

    typedef enum logic [3:0] {
        PH_ZH0  = 4'd0,
        PH_ZH1  = 4'd1,
        PH_BH0  = 4'd2,
        PH_BH1  = 4'd3,
        PH_BH2  = 4'd4,
        PH_BH3  = 4'd5,
        PH_BH4  = 4'd6,
        PH_DATA = 4'd7,
        PH_AD0  = 4'd8,
        PH_AD1  = 4'd9,
        PH_AD2  = 4'd10,
        PH_AD3  = 4'd11
    } t_phase;

endpackage

// ===== rtl/zsbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_front: item intake and classification
// Keeps the stream counters and the running Adler-32, and turns every
// accepted item into one job descriptor for the output sequencer.
// ----------------------------------------------------------------------------
module zsbf_front
    import zsbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_command,
    input  logic [7:0]  i_in_byte,
    input  logic [31:0] i_stream_length,
    output t_job        o_job
);

    logic [31:0] r_bytes_left;
    logic [15:0] r_block_left;
    logic [15:0] r_sum_a;
    logic [15:0] r_sum_b;
    logic        r_active;

    logic [31:0] n_bytes_left;
    logic [15:0] n_block_left;
    logic [15:0] n_sum_a;
    logic [15:0] n_sum_b;
    logic        n_active;

    logic [16:0] w_a_raw;
    logic [15:0] w_a_mod;
    logic [16:0] w_b_raw;
    logic [15:0] w_b_mod;
    logic [15:0] w_len;
    logic        w_hdr;

    // Adler-32 step: both sums stay below the modulus, so one subtract each.
    always_comb begin
        w_a_raw = {1'b0, r_sum_a} + {9'd0, i_in_byte};
        w_a_mod = (w_a_raw >= ADLER_MOD) ? 16'(w_a_raw - ADLER_MOD) : w_a_raw[15:0];
        w_b_raw = {1'b0, r_sum_b} + {1'b0, w_a_mod};
        w_b_mod = (w_b_raw >= ADLER_MOD) ? 16'(w_b_raw - ADLER_MOD) : w_b_raw[15:0];
        w_len   = (r_bytes_left < MAX_BLOCK) ? r_bytes_left[15:0] : MAX_BLOCK[15:0];
        w_hdr   = (r_block_left == 16'd0);
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_block_left = r_block_left;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_active     = r_active;

        o_job.kind      = K_DATA;
        o_job.hdr       = 1'b0;
        o_job.bfinal    = (r_bytes_left <= MAX_BLOCK);
        o_job.len       = w_len;
        o_job.data      = i_in_byte;
        o_job.adler     = 1'b0;
        o_job.adler_val = {w_b_mod, w_a_mod};

        priority if (!i_command) begin
            o_job.kind      = K_START;
            o_job.adler     = (i_stream_length == 32'd0);
            o_job.adler_val = ADLER_INIT;
            n_bytes_left    = i_stream_length;
            n_block_left    = 16'd0;
            n_sum_a         = ADLER_INIT[15:0];
            n_sum_b         = 16'd0;
            n_active        = (i_stream_length != 32'd0);
        end else if (!r_active) begin
            o_job.kind = K_MISUSE;
        end else begin
            o_job.hdr    = w_hdr;
            o_job.adler  = (r_bytes_left == 32'd1);
            n_block_left = (w_hdr ? w_len : r_block_left) - 16'd1;
            n_bytes_left = r_bytes_left - 32'd1;
            n_sum_a      = w_a_mod;
            n_sum_b      = w_b_mod;
            n_active     = (r_bytes_left != 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 32'd0;
            r_block_left <= 16'd0;
            r_sum_a      <= ADLER_INIT[15:0];
            r_sum_b      <= 16'd0;
            r_active     <= 1'b0;
        end else if (i_accept) begin
            r_bytes_left <= n_bytes_left;
            r_block_left <= n_block_left;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_active     <= n_active;
        end
    end

endmodule

// ===== rtl/zsbf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_queue: job queue between intake and output sequencer
// A small first-in first-out store of job descriptors; the head is visible
// without a read cycle.
// ----------------------------------------------------------------------------
module zsbf_queue
    import zsbf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/zsbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_back: output sequencer
// Walks the head job through its byte phases, one byte a cycle while the output
// is not stalled, into the output register, and releases the job with its last byte.
// ----------------------------------------------------------------------------
module zsbf_back
    import zsbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic       o_misuse
);

    t_phase r_phase;
    logic   r_mid;
    t_phase w_cur;
    t_phase n_phase;
    logic   w_last;
    logic   w_load;
    logic [7:0] w_byte;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_stream_end;
    logic       r_misuse;

    assign w_load = !i_empty && (!r_valid || !i_stall);
    assign o_pop  = w_load && w_last;

    // Current phase and next phase.
    always_comb begin
        priority if (r_mid) begin
            w_cur = r_phase;
        end else if (i_head.kind == K_START) begin
            w_cur = PH_ZH0;
        end else if (i_head.kind == K_DATA && i_head.hdr) begin
            w_cur = PH_BH0;
        end else begin
            w_cur = PH_DATA;
        end

        n_phase = w_cur;
        w_last  = 1'b0;
        unique case (w_cur)
            PH_ZH0:  n_phase = PH_ZH1;
            PH_ZH1:  if (i_head.adler) n_phase = PH_AD0; else w_last = 1'b1;
            PH_BH0:  n_phase = PH_BH1;
            PH_BH1:  n_phase = PH_BH2;
            PH_BH2:  n_phase = PH_BH3;
            PH_BH3:  n_phase = PH_BH4;
            PH_BH4:  n_phase = PH_DATA;
            PH_DATA: if (i_head.adler) n_phase = PH_AD0; else w_last = 1'b1;
            PH_AD0:  n_phase = PH_AD1;
            PH_AD1:  n_phase = PH_AD2;
            PH_AD2:  n_phase = PH_AD3;
            PH_AD3:  w_last = 1'b1;
            default: w_last = 1'b1;
        endcase
    end

    // Byte selected by the current phase.
    always_comb begin
        unique case (w_cur)
            PH_ZH0:  w_byte = ZLIB_CMF;
            PH_ZH1:  w_byte = ZLIB_FLG;
            PH_BH0:  w_byte = {7'd0, i_head.bfinal};
            PH_BH1:  w_byte = i_head.len[7:0];
            PH_BH2:  w_byte = i_head.len[15:8];
            PH_BH3:  w_byte = ~i_head.len[7:0];
            PH_BH4:  w_byte = ~i_head.len[15:8];
            PH_DATA: w_byte = (i_head.kind == K_MISUSE) ? 8'd0 : i_head.data;
            PH_AD0:  w_byte = i_head.adler_val[31:24];
            PH_AD1:  w_byte = i_head.adler_val[23:16];
            PH_AD2:  w_byte = i_head.adler_val[15:8];
            PH_AD3:  w_byte = i_head.adler_val[7:0];
            default: w_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= PH_ZH0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_mid   <= !w_last;
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte       <= w_byte;
            r_run_last   <= w_last;
            r_stream_end <= (w_cur == PH_AD3);
            r_misuse     <= (i_head.kind == K_MISUSE);
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;
    assign o_misuse     = r_misuse;

endmodule

// ===== rtl/zlib_stored_block_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zlib_stored_block_framer: zlib stream of stored deflate blocks
// Frames a payload byte stream of configured length as a zlib stream with
// stored-block headers and a trailing big-endian Adler-32.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_command, i_in_byte
//   output    out        o_valid / i_stall    o_out_byte, o_run_last,
//                                             o_stream_end, o_misuse
//   config    in         APB write strobe     pwdata -> stream_length
//
// One item is taken per cycle while the job queue has room; the front part
// updates counters and checksum in the cycle of acceptance.
// The output register sends one byte a cycle while the receiver does not stall;
// an item causes one output byte when it is a plain payload byte, and up to 10 when a
// block header and the checksum fall on the same item.
// A synchronous active-low reset clears the counters, the queue and the
// output register. o_stall is high only while the queue is full.
// ----------------------------------------------------------------------------
module zlib_stored_block_framer
    import zsbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic        o_misuse,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_stream_length;
    logic        w_accept;
    logic        w_full;
    logic        w_empty;
    logic        w_pop;
    t_job        w_job;
    t_job        w_head;

    assign pready = 1'b1;

    // Only one register, at byte address zero; writes to other offsets are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= 32'd0;
        end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
            r_stream_length <= pwdata;
        end
    end

    assign prdata   = r_stream_length;
    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    zsbf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_command       (i_command),
        .i_in_byte       (i_in_byte),
        .i_stream_length (r_stream_length),
        .o_job           (w_job)
    );

    zsbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    zsbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_misuse     (o_misuse)
    );

endmodule

// ===== rtl/zsbf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_checker: port-level checks of the framer
// Watches the top-level ports over time and flags impossible combinations
// of the result flags and a broken output hold.
// ----------------------------------------------------------------------------
module zsbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_run_last,
    input logic        o_stream_end,
    input logic        o_misuse
);

    // A result waiting on a stalled receiver keeps its bytes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output item changed while stalled");

    // The final checksum byte always closes the item that caused it.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_end |-> o_run_last && !o_misuse)
        else $error("stream end without run end");

    // A misuse item is a single zero byte outside any stream.
    a_misuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_misuse |-> o_run_last && !o_stream_end && (o_out_byte == 8'd0))
        else $error("malformed misuse item");

    // Reset empties the queue and the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && !o_valid)
        else $error("queue or output not cleared by reset");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the zlib stored-block framer
// Feeds start commands and payload bytes through the valid/stall input,
// programmes the stream length over the APB port between streams and checks
// every output byte, with its run, end and misuse flags, against a running
// prediction of the zlib framing and Adler-32. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb
    import zsbf_pkg::*;
;

    localparam logic       CMD_START          = 1'b0;
    localparam logic       CMD_BYTE           = 1'b1;
    localparam logic [1:0] ADDR_STREAM_LENGTH = 2'd0;
    localparam int         RANDOM_ITEMS       = 200;
    localparam int         SETTLE_CYCLES      = 12;
    localparam int         LONG_HOLD          = 80;
    localparam int         MAX_REPORTS        = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fin;
        logic       misuse;
    } t_zbyte;

    // Tracks the framer state and queues the bytes each accepted item must cause.
    class zstream_scoreboard;
        logic [31:0] length_reg;
        logic [31:0] bytes_left;
        logic [15:0] block_left;
        logic [16:0] sum_a;
        logic [16:0] sum_b;
        bit          in_stream;
        t_zbyte      frame_bytes[$];
        t_zbyte      burst[$];
        int          mismatches;
        int          compared;
        int          items;
        int          starts;

        function new();
            length_reg = '0;
            bytes_left = '0;
            block_left = '0;
            sum_a      = ADLER_INIT[16:0];
            sum_b      = '0;
            in_stream  = 1'b0;
            mismatches = 0;
            compared   = 0;
            items      = 0;
            starts     = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function t_zbyte mk(logic [7:0] d, logic fin, logic bad);
            t_zbyte b;
            b.data   = d;
            b.last   = 1'b0;
            b.fin    = fin;
            b.misuse = bad;
            return b;
        endfunction

        function void add_checksum();
            burst.push_back(mk(sum_b[15:8], 1'b0, 1'b0));
            burst.push_back(mk(sum_b[7:0], 1'b0, 1'b0));
            burst.push_back(mk(sum_a[15:8], 1'b0, 1'b0));
            burst.push_back(mk(sum_a[7:0], 1'b1, 1'b0));
            in_stream = 1'b0;
        endfunction

        function void take_item(logic cmd, logic [7:0] d);
            logic [31:0] len;
            t_zbyte      tail;
            items++;
            burst.delete();
            if (cmd == CMD_START) begin
                starts++;
                bytes_left = length_reg;
                block_left = '0;
                sum_a      = ADLER_INIT[16:0];
                sum_b      = '0;
                in_stream  = 1'b1;
                burst.push_back(mk(ZLIB_CMF, 1'b0, 1'b0));
                burst.push_back(mk(ZLIB_FLG, 1'b0, 1'b0));
                if (bytes_left == 0)
                    add_checksum();
            end else if (!in_stream) begin
                burst.push_back(mk(8'h00, 1'b0, 1'b1));
            end else begin
                if (block_left == 0) begin
                    len = (bytes_left < MAX_BLOCK) ? bytes_left : MAX_BLOCK;
                    burst.push_back(mk({7'd0, len == bytes_left}, 1'b0, 1'b0));
                    burst.push_back(mk(len[7:0], 1'b0, 1'b0));
                    burst.push_back(mk(len[15:8], 1'b0, 1'b0));
                    burst.push_back(mk(~len[7:0], 1'b0, 1'b0));
                    burst.push_back(mk(~len[15:8], 1'b0, 1'b0));
                    block_left = len[15:0];
                end
                burst.push_back(mk(d, 1'b0, 1'b0));
                sum_a = sum_a + d;
                if (sum_a >= ADLER_MOD)
                    sum_a = sum_a - ADLER_MOD;
                sum_b = sum_b + sum_a;
                if (sum_b >= ADLER_MOD)
                    sum_b = sum_b - ADLER_MOD;
                block_left = block_left - 16'd1;
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0)
                    add_checksum();
            end
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
            foreach (burst[i])
                frame_bytes.push_back(burst[i]);
        endfunction

        function void check_byte(logic [7:0] d, logic last, logic fin, logic bad);
            t_zbyte want;
            if (frame_bytes.size() == 0) begin
                report($sformatf("unexpected result byte %02h", d));
                return;
            end
            want = frame_bytes.pop_front();
            compared++;
            if (d !== want.data)
                report($sformatf("byte %0d: out_byte %02h, wanted %02h",
                                 compared, d, want.data));
            if (last !== want.last)
                report($sformatf("byte %0d: run_last %b, wanted %b",
                                 compared, last, want.last));
            if (fin !== want.fin)
                report($sformatf("byte %0d: stream_end %b, wanted %b",
                                 compared, fin, want.fin));
            if (bad !== want.misuse)
                report($sformatf("byte %0d: misuse %b, wanted %b",
                                 compared, bad, want.misuse));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_START;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_stream_end;
    logic        o_misuse;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = ADDR_STREAM_LENGTH;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    zstream_scoreboard sb = new();

    bit no_gaps = 1'b0;
    int hold_ask = 0;
    int hold_seen = 0;
    int stall_left = 0;
    int run_left = 0;
    int rx_pick = 0;
    int pick = 0;
    int random_items = 0;
    int length_writes = 0;

    zlib_stored_block_framer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_misuse     (o_misuse),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d bytes still awaited.", sb.frame_bytes.size());
        $display("TEST FAILED");
        $finish;
    end

    // Both handshakes are observed with the values that stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.take_item(i_command, i_in_byte);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_byte(o_out_byte, o_run_last, o_stream_end, o_misuse);
    end

    // Receiver: short stalls, calm stretches, and a long hold on request.
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen  = hold_ask;
            stall_left = LONG_HOLD;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (run_left != 0) begin
                run_left = run_left - 1;
            end else begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 10) begin
                    run_left = $urandom_range(20, 80);
                end else begin
                    run_left = $urandom_range(0, 4);
                    stall_left = (rx_pick < 95) ? $urandom_range(1, 3)
                                                : $urandom_range(8, 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid   <= 1'b0;
            i_command <= 1'($urandom_range(0, 1));
            i_in_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_in_byte <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Stops offering items and waits until every predicted byte has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.frame_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [31:0] v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STREAM_LENGTH;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.length_reg = v;
        length_writes++;
    endtask

    initial begin
        logic [31:0] len;
        int          count;
        int          restart_at;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A byte with no stream, then a start on the reset length of zero.
        send_item(CMD_BYTE, 8'hA5);
        send_item(CMD_START, 8'hFF);
        send_item(CMD_BYTE, 8'hFF);

        write_length(32'd3);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h80);

        // Full-size first block, abandoned by a second start.
        write_length(32'hFFFF_FFFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h01);
        send_item(CMD_START, 8'h5A);
        send_item(CMD_BYTE, 8'h55);

        // One byte: block header, data and checksum all fall on one item.
        write_length(32'd1);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'h7F);

        write_length(32'd2);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'h12);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'hFE);
        send_item(CMD_BYTE, 8'h01);

        // A long hold on the output while the input keeps pushing.
        write_length(32'd48);
        no_gaps = 1'b1;
        hold_ask <= hold_ask + 1;
        send_item(CMD_START, 8'h00);
        send_bytes(48);
        no_gaps = 1'b0;

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = 32'd0;
            else if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 92)
                len = $urandom_range(13, 60);
            else
                len = $urandom;
            write_length(len);
            no_gaps = ($urandom_range(0, 4) == 0);

            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
                random_items++;
            end
            send_item(CMD_START, 8'($urandom_range(0, 255)));
            random_items++;

            count = (len > 64) ? $urandom_range(2, 24) : int'(len);
            if (count > 0 && $urandom_range(0, 6) == 0)
                count = $urandom_range(0, count - 1);
            restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count) : -1;
            for (int i = 0; i < count; i++) begin
                if (i == restart_at) begin
                    send_item(CMD_START, 8'($urandom_range(0, 255)));
                    random_items++;
                end
                send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
                random_items++;
            end

            // Stray bytes after the stream has closed, or into one cut short.
            if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, 2);
                send_bytes(count);
                random_items += count;
            end
        end

        wait_drained();
        if (sb.frame_bytes.size() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.frame_bytes.size()));

        $display("Covered %0d items over %0d stream starts and %0d length settings,",
                 sb.items, sb.starts, length_writes);
        $display("with empty, cut-short and full-block streams; %0d bytes, %0d mismatches.",
                 sb.compared, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
